/* rtl/multi_index_sorted_table_defines.svh */
// Assertion macros for the sorted record table checker.
// Used by the checker file only; depends on nothing else.
`ifndef MULTI_INDEX_SORTED_TABLE_DEFINES_SVH
`define MULTI_INDEX_SORTED_TABLE_DEFINES_SVH

// Check a property while out of reset.
`define MIST_CHECK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included.
`define MIST_CHECK_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/mist_pkg.sv */
// Shared types and constants for the sorted record table.
// No dependencies; used by the top level and its checker.
package mist_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam logic       OP_ADD       = 1'b0;
   localparam logic       OP_READ      = 1'b1;
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_INSERT,
      ST_RD_IDX,
      ST_RD_REC,
      ST_RD_DATA,
      ST_RESP
   } state_type;

endpackage

/* rtl/multi_index_sorted_table.sv */
// Sorted record table: record stores plus two sorted slot indices.
// Depends on mist_pkg.
//
// Use: one request word in, one response word out, strictly in order.
// req_tuser is the opcode (add or read). An add appends key, tag and name
// to the record stores and inserts the new slot into both sort orders at
// its upper bound, so equal records keep arrival order. A read returns the
// record at req rank of the chosen order. rsp_tuser carries the status.
// An add makes one pass over the record store (one compare per cycle in the
// shared compare unit) to count both insert positions, then a pass over the
// index memories that moves one entry per cycle through their single write
// port. A read does an index read, then a record read. A full add or a bad
// rank goes straight to the response. The block takes one word at a time:
// req_tready is high only when idle. After reset the table holds no records;
// stores are not cleared. A stalled receiver holds the response word in place
// and keeps the block busy until it is taken.
module multi_index_sorted_table (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [31:0] key_value, [63:32] tag_value, [127:64] name_word,
   // [128] which_index, [134:129] rank, [135] zero
   input  logic [135:0] req_tdata,
   // [0] op
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] out_key, [63:32] out_tag, [127:64] out_name,
   // [134:128] entries, [135] zero
   output logic [135:0] rsp_tdata,
   // [1:0] status
   output logic [1:0]   rsp_tuser
);

   localparam int AW = mist_pkg::ADDR_W;
   localparam int CW = mist_pkg::CNT_W;

   mist_pkg::state_type state_ff, state_in;

   // record and index memories
   logic [31:0]   key_mem  [mist_pkg::CAPACITY];
   logic [31:0]   tag_mem  [mist_pkg::CAPACITY];
   logic [63:0]   name_mem [mist_pkg::CAPACITY];
   logic [AW-1:0] ord0_mem [mist_pkg::CAPACITY];
   logic [AW-1:0] ord1_mem [mist_pkg::CAPACITY];

   logic [31:0]   key_rd_ff, tag_rd_ff;
   logic [63:0]   name_rd_ff;
   logic [AW-1:0] ord0_rd_ff, ord1_rd_ff;

   // latched request
   logic [31:0]   key_ff, tag_ff;
   logic [63:0]   name_ff;
   logic          which_ff;
   logic [5:0]    rank_ff;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic          scan_vld_ff, scan_vld_in;
   logic [CW-1:0] pos0_ff, pos0_in, pos1_ff, pos1_in;
   logic [CW-1:0] sh_cnt_ff, sh_cnt_in;
   logic [AW-1:0] sh_src_ff, sh_src_in;
   logic          sh_vld_ff, sh_vld_in;

   logic [1:0]    status_ff, status_in;
   logic [31:0]   okey_ff, okey_in, otag_ff, otag_in;
   logic [63:0]   oname_ff, oname_in;

   logic          req_acc, is_add, full, bad_rank;
   logic          scan_issue, sh_issue;
   logic [AW-1:0] st_ra, ord_ra, slot_sel;
   logic          st_we, ord0_we, ord1_we;
   logic [AW-1:0] ord0_wa, ord1_wa;
   logic [AW-1:0] ord0_wd, ord1_wd;
   logic          le_key, le_key_name;

   assign req_acc  = req_tvalid && req_tready;
   assign is_add   = (req_tuser == mist_pkg::OP_ADD);
   assign full     = (count_ff == CW'(mist_pkg::CAPACITY));
   assign bad_rank = ({{(CW-6){1'b0}}, req_tdata[134:129]} >= count_ff);
   assign slot_sel = which_ff ? ord1_rd_ff : ord0_rd_ff;

   // shared compare unit: is the scanned record not greater than the new one
   assign le_key      = ($signed(key_rd_ff) <= $signed(key_ff));
   assign le_key_name = ($signed(key_rd_ff) < $signed(key_ff)) ||
                        ((key_rd_ff == key_ff) && (name_rd_ff <= name_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mist_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (is_add) begin
                  state_in = full ? mist_pkg::ST_RESP : mist_pkg::ST_SCAN;
               end else begin
                  state_in = bad_rank ? mist_pkg::ST_RESP : mist_pkg::ST_RD_IDX;
               end
            end
         end
         mist_pkg::ST_SCAN: begin
            if ((ptr_ff >= count_ff) && !scan_vld_ff) state_in = mist_pkg::ST_SHIFT;
         end
         mist_pkg::ST_SHIFT: begin
            if ((sh_cnt_ff == '0) && !sh_vld_ff) state_in = mist_pkg::ST_INSERT;
         end
         mist_pkg::ST_INSERT:  state_in = mist_pkg::ST_RESP;
         mist_pkg::ST_RD_IDX:  state_in = mist_pkg::ST_RD_REC;
         mist_pkg::ST_RD_REC:  state_in = mist_pkg::ST_RD_DATA;
         mist_pkg::ST_RD_DATA: state_in = mist_pkg::ST_RESP;
         mist_pkg::ST_RESP: begin
            if (rsp_tready) state_in = mist_pkg::ST_IDLE;
         end
         default: state_in = mist_pkg::ST_IDLE;
      endcase
   end

   // control outputs of the sequencer
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      scan_issue = 1'b0;
      sh_issue   = 1'b0;
      st_ra      = ptr_ff[AW-1:0];
      ord_ra     = rank_ff[AW-1:0];
      ord0_we    = 1'b0;
      ord1_we    = 1'b0;
      ord0_wa    = sh_src_ff + AW'(1);
      ord1_wa    = sh_src_ff + AW'(1);
      ord0_wd    = ord0_rd_ff;
      ord1_wd    = ord1_rd_ff;
      case (state_ff)
         mist_pkg::ST_IDLE: req_tready = 1'b1;
         mist_pkg::ST_SCAN: scan_issue = (ptr_ff < count_ff);
         mist_pkg::ST_SHIFT: begin
            sh_issue = (sh_cnt_ff != '0);
            ord_ra   = sh_cnt_ff[AW-1:0] - AW'(1);
            // move entries at or above the insert point up by one
            ord0_we  = sh_vld_ff && ({1'b0, sh_src_ff} >= pos0_ff);
            ord1_we  = sh_vld_ff && ({1'b0, sh_src_ff} >= pos1_ff);
         end
         mist_pkg::ST_INSERT: begin
            ord0_we = 1'b1;
            ord1_we = 1'b1;
            ord0_wa = pos0_ff[AW-1:0];
            ord1_wa = pos1_ff[AW-1:0];
            ord0_wd = count_ff[AW-1:0];
            ord1_wd = count_ff[AW-1:0];
         end
         mist_pkg::ST_RD_REC: st_ra = slot_sel;
         mist_pkg::ST_RESP:   rsp_tvalid = 1'b1;
         default: ;
      endcase
   end

   assign st_we = req_acc && is_add && !full;

   // datapath next values
   always_comb begin
      count_in    = count_ff;
      ptr_in      = ptr_ff;
      scan_vld_in = scan_issue;
      pos0_in     = pos0_ff;
      pos1_in     = pos1_ff;
      sh_cnt_in   = sh_cnt_ff;
      sh_src_in   = sh_src_ff;
      sh_vld_in   = sh_issue;
      status_in   = status_ff;
      okey_in     = okey_ff;
      otag_in     = otag_ff;
      oname_in    = oname_ff;
      if (req_acc) begin
         ptr_in    = '0;
         pos0_in   = '0;
         pos1_in   = '0;
         sh_cnt_in = count_ff;
         okey_in   = '0;
         otag_in   = '0;
         oname_in  = '0;
         if (is_add) begin
            status_in = full ? mist_pkg::STATUS_FULL : mist_pkg::STATUS_OK;
         end else begin
            status_in = bad_rank ? mist_pkg::STATUS_RANGE : mist_pkg::STATUS_OK;
         end
      end
      if (scan_issue) ptr_in = ptr_ff + CW'(1);
      if (scan_vld_ff) begin
         pos0_in = pos0_ff + CW'(le_key);
         pos1_in = pos1_ff + CW'(le_key_name);
      end
      if (sh_issue) begin
         sh_cnt_in = sh_cnt_ff - CW'(1);
         sh_src_in = ord_ra;
      end
      if (state_ff == mist_pkg::ST_INSERT) count_in = count_ff + CW'(1);
      if (state_ff == mist_pkg::ST_RD_DATA) begin
         okey_in  = key_rd_ff;
         otag_in  = tag_rd_ff;
         oname_in = name_rd_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= mist_pkg::ST_IDLE;
         count_ff    <= '0;
         scan_vld_ff <= 1'b0;
         sh_vld_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         scan_vld_ff <= scan_vld_in;
         sh_vld_ff   <= sh_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_acc) begin
         key_ff   <= req_tdata[31:0];
         tag_ff   <= req_tdata[63:32];
         name_ff  <= req_tdata[127:64];
         which_ff <= req_tdata[128];
         rank_ff  <= req_tdata[134:129];
      end
      ptr_ff    <= ptr_in;
      pos0_ff   <= pos0_in;
      pos1_ff   <= pos1_in;
      sh_cnt_ff <= sh_cnt_in;
      sh_src_ff <= sh_src_in;
      status_ff <= status_in;
      okey_ff   <= okey_in;
      otag_ff   <= otag_in;
      oname_ff  <= oname_in;
   end

   // record stores: write the new record at accept, read one slot a cycle
   always_ff @(posedge clock) begin
      if (st_we) begin
         key_mem[count_ff[AW-1:0]]  <= req_tdata[31:0];
         tag_mem[count_ff[AW-1:0]]  <= req_tdata[63:32];
         name_mem[count_ff[AW-1:0]] <= req_tdata[127:64];
      end
      key_rd_ff  <= key_mem[st_ra];
      tag_rd_ff  <= tag_mem[st_ra];
      name_rd_ff <= name_mem[st_ra];
   end

   // sort indices: one read and one write port each
   always_ff @(posedge clock) begin
      if (ord0_we) ord0_mem[ord0_wa] <= ord0_wd;
      ord0_rd_ff <= ord0_mem[ord_ra];
   end

   always_ff @(posedge clock) begin
      if (ord1_we) ord1_mem[ord1_wa] <= ord1_wd;
      ord1_rd_ff <= ord1_mem[ord_ra];
   end

   assign rsp_tuser = status_ff;
   assign rsp_tdata = {1'b0, count_ff, oname_ff, otag_ff, okey_ff};

endmodule

/* rtl/mist_checker.sv */
// Port-level checks for the sorted record table, bound to the top level.
// Depends on mist_pkg and multi_index_sorted_table_defines.svh.
`include "multi_index_sorted_table_defines.svh"

module mist_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [135:0] req_tdata,
   input logic         req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [135:0] rsp_tdata,
   input logic [1:0]   rsp_tuser
);

   `MIST_CHECK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "response word changed while stalled")
   `MIST_CHECK(a_busy_after_req, clock, reset, req_tvalid && req_tready |=> !req_tready, "took a second word while busy")
   `MIST_CHECK_ALWAYS(a_no_overlap, clock, rsp_tvalid |-> !req_tready, "ready while response pending")
   `MIST_CHECK(a_full_count, clock, reset, rsp_tvalid && (rsp_tuser == mist_pkg::STATUS_FULL) |-> (rsp_tdata[134:128] == 7'(mist_pkg::CAPACITY)), "full status with room left")
   `MIST_CHECK(a_range_zero, clock, reset, rsp_tvalid && (rsp_tuser == mist_pkg::STATUS_RANGE) |-> (rsp_tdata[127:0] == '0), "data on bad rank")

endmodule

bind multi_index_sorted_table mist_checker u_mist_checker (.*);

/* tb/mist_checker.sv */
// Response checker for the sorted record table: watches both streams,
// predicts each response word from its own table copy and compares.
// Depends on mist_pkg.
`timescale 1ns / 1ps
module mist_scoreboard (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [135:0] req_tdata,
   input  logic         req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [135:0] rsp_tdata,
   input  logic [1:0]   rsp_tuser,
   output int           fail_count,
   output int           pending
);

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] key;
      logic [31:0] tag;
      logic [63:0] name;
      logic [6:0]  entries;
   } table_rsp_type;

   logic signed [31:0] key_mem [mist_pkg::CAPACITY];
   logic [31:0]        tag_mem [mist_pkg::CAPACITY];
   logic [63:0]        name_mem[mist_pkg::CAPACITY];
   int                 by_key  [mist_pkg::CAPACITY];
   int                 by_kname[mist_pkg::CAPACITY];
   int                 held;
   table_rsp_type      expected_q[$];

   // true when slot a orders strictly ahead of slot b
   function automatic bit ahead(int a, int b, bit use_name);
      if (key_mem[a] != key_mem[b]) return key_mem[a] < key_mem[b];
      return use_name && (name_mem[a] < name_mem[b]);
   endfunction

   function automatic table_rsp_type apply_word(logic op, logic [135:0] d);
      table_rsp_type r;
      int            p;
      int            rk;
      int            s;
      r = '0;
      if (op == mist_pkg::OP_ADD) begin
         if (held >= mist_pkg::CAPACITY) begin
            r.status = mist_pkg::STATUS_FULL;
         end else begin
            key_mem[held]  = d[31:0];
            tag_mem[held]  = d[63:32];
            name_mem[held] = d[127:64];
            p = 0;
            while (p < held && !ahead(held, by_key[p], 1'b0)) p++;
            for (int i = held; i > p; i--) by_key[i] = by_key[i-1];
            by_key[p] = held;
            p = 0;
            while (p < held && !ahead(held, by_kname[p], 1'b1)) p++;
            for (int i = held; i > p; i--) by_kname[i] = by_kname[i-1];
            by_kname[p] = held;
            held++;
         end
      end else begin
         rk = d[134:129];
         if (rk >= held) begin
            r.status = mist_pkg::STATUS_RANGE;
         end else begin
            s      = d[128] ? by_kname[rk] : by_key[rk];
            r.key  = key_mem[s];
            r.tag  = tag_mem[s];
            r.name = name_mem[s];
         end
      end
      r.entries = held[6:0];
      return r;
   endfunction

   assign pending = expected_q.size();

   always @(posedge clock) begin
      table_rsp_type e;
      table_rsp_type got;
      table_rsp_type nxt;
      if (reset) begin
         held = 0;
         fail_count <= 0;
         expected_q.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            nxt = apply_word(req_tuser, req_tdata);
            expected_q.insert(expected_q.size(), nxt);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[127:64],
                   rsp_tdata[134:128]};
            if (expected_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected response word %h", got);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_q.pop_front();
               if (got !== e || rsp_tdata[135] !== 1'b0) begin
                  if (fail_count < 10)
                     $display({"mismatch: exp st=%0d k=%h t=%h n=%h e=%0d",
                               " got st=%0d k=%h t=%h n=%h e=%0d"},
                              e.status, e.key, e.tag, e.name, e.entries, got.status,
                              got.key, got.tag, got.name, got.entries);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

/* tb/tb_top.sv */
// Stimulus and verdict for the sorted record table regression.
// Depends on mist_pkg, multi_index_sorted_table and mist_scoreboard.
`timescale 1ns / 1ps
module tb_top;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;
   logic         req_tuser = mist_pkg::OP_ADD;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [135:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   int           fail_count;
   int           pending;
   int           cycle_count = 0;
   int           held_guess = 0;
   bit           sending = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   multi_index_sorted_table u_top (.*);

   mist_scoreboard u_checker (.*);

   // Give up well past the slowest legal run (~1850 words with stalls included).
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("multi_index_sorted_table regression: fail");
         $finish;
      end
   end

   // Receiver: stall with a drifting probability, some stretches never stall.
   always @(negedge clock) begin
      int mode;
      mode = (cycle_count / 3000) % 4;
      if (mode == 0) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 3) >= mode - 1);
   end

   // Drive one word and hold it until accepted.
   task automatic send_word(logic op, logic signed [31:0] key, logic [31:0] tag,
                            logic [63:0] name, logic which, logic [5:0] rank);
      req_tuser  <= op;
      req_tdata  <= {1'b0, rank, which, name, tag, key};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      if (op == mist_pkg::OP_ADD && held_guess < mist_pkg::CAPACITY) held_guess++;
   endtask

   task automatic idle_gap();
      req_tvalid <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clock);
   endtask

   // Keys often from a small pool so ties are common, sometimes extreme.
   function automatic logic [31:0] pick_key();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 3) << 16;
         1: return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff};
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [63:0] pick_name();
      if ($urandom_range(0, 1)) return {8'($urandom_range(0, 2)), 56'h0};
      return {$urandom(), $urandom()};
   endfunction

   task automatic random_word();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4)
         send_word(mist_pkg::OP_ADD, pick_key(), $urandom(), pick_name(),
                   1'($urandom_range(0, 1)), 6'($urandom()));
      else if (r < 9 && held_guess > 0)
         send_word(mist_pkg::OP_READ, $urandom(), $urandom(), {$urandom(), $urandom()},
                   1'($urandom_range(0, 1)), 6'($urandom_range(0, held_guess - 1)));
      else
         send_word(mist_pkg::OP_READ, $urandom(), $urandom(), {$urandom(), $urandom()},
                   1'($urandom_range(0, 1)), 6'($urandom()));
   endtask

   initial begin
      int burst;
      int sent;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty reads, extremes, ties on key and name.
      send_word(mist_pkg::OP_READ, '0, '0, '0, 1'b0, 6'd0);
      send_word(mist_pkg::OP_READ, '0, '0, '0, 1'b1, 6'd63);
      send_word(mist_pkg::OP_ADD, 32'h7fff_ffff, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff,
                1'b1, 6'd63);
      send_word(mist_pkg::OP_ADD, 32'h8000_0000, 32'h8000_0000, 64'h0, 1'b0, 6'd0);
      send_word(mist_pkg::OP_ADD, 32'h0001_0000, 32'h1, 64'h6262_6200_0000_0000,
                1'b0, 6'd0);
      send_word(mist_pkg::OP_ADD, 32'h0001_0000, 32'h2, 64'h6161_6100_0000_0000,
                1'b0, 6'd0);
      send_word(mist_pkg::OP_ADD, 32'h0001_0000, 32'h3, 64'h6161_6100_0000_0000,
                1'b0, 6'd0);
      for (int i = 0; i < 5; i++) begin
         send_word(mist_pkg::OP_READ, '0, '0, '0, 1'b0, 6'(i));
         send_word(mist_pkg::OP_READ, '0, '0, '0, 1'b1, 6'(i));
      end
      send_word(mist_pkg::OP_READ, '0, '0, '0, 1'b1, 6'd5);

      // Random: bursts and gaps; refill past full then restart from reset
      // is not allowed, so the table fills once and stays full for the tail.
      sent = 0;
      while (sent < 1850) begin
         burst = $urandom_range(1, 20);
         for (int i = 0; i < burst; i++) random_word();
         sent += burst;
         idle_gap();
      end
      req_tvalid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) $display("multi_index_sorted_table regression: pass");
      else $display("multi_index_sorted_table regression: fail");
      $finish;
   end

endmodule
